// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RME_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Consequent must hold in the cycle after the antecedent.
`define RME_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: hdl/rme_pkg.sv
package rme_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned CNT_W     = $clog2(PROD_W);
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [PROD_W-1:0] t_prod;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PUBLIC_EXP  = 2'd0,
        CFG_PRIVATE_EXP = 2'd1,
        CFG_MODULUS     = 2'd2
    } t_cfg_idx;

    // Operation codes carried in tuser.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture message, exponent and modulus
        logic mul;       // form both 64-bit products
        logic red_step;  // one bit of the restoring reduction
        logic update;    // write back reduced values, shift exponent
        logic emit;      // copy accumulator to the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_zero;  // no exponent bits left
        logic mod_zero;  // modulus of zero stands for 2^32
        logic red_last;  // current reduction step is the final one
    } t_dp_status;

endpackage

// File: hdl/rme_datapath.sv
`include "assert_macros.svh"

module rme_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rme_pkg::t_dp_cmd    i_cmd,
    output rme_pkg::t_dp_status o_status,
    input  rme_pkg::t_word      i_message,
    input  logic                i_operation,
    input  rme_pkg::t_word      i_public_exp,
    input  rme_pkg::t_word      i_private_exp,
    input  rme_pkg::t_word      i_modulus,
    output rme_pkg::t_word      o_result
);

    localparam rme_pkg::t_word WORD_ONE = rme_pkg::t_word'(1);
    localparam logic [rme_pkg::CNT_W-1:0] CNT_LAST = rme_pkg::CNT_W'(rme_pkg::PROD_W - 1);

    rme_pkg::t_word r_acc;
    rme_pkg::t_word r_sq;
    rme_pkg::t_word r_exp;
    rme_pkg::t_word r_mod;
    logic           r_mod_zero;
    rme_pkg::t_prod r_prod_a;
    rme_pkg::t_prod r_prod_s;
    rme_pkg::t_word r_rem_a;
    rme_pkg::t_word r_rem_s;
    logic [rme_pkg::CNT_W-1:0] r_cnt;
    rme_pkg::t_word r_result;

    rme_pkg::t_word n_rem_a;
    rme_pkg::t_word n_rem_s;

    // One step of restoring reduction: shift in the next product bit and
    // subtract the modulus when the partial remainder reaches it.
    function automatic rme_pkg::t_word red_bit(rme_pkg::t_word rem, logic din,
                                               rme_pkg::t_word m);
        logic [rme_pkg::DATA_W:0] t;
        t = {rem, din};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[rme_pkg::DATA_W-1:0];
    endfunction

    always_comb begin
        n_rem_a = red_bit(r_rem_a, r_prod_a[rme_pkg::PROD_W-1], r_mod);
        n_rem_s = red_bit(r_rem_s, r_prod_s[rme_pkg::PROD_W-1], r_mod);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sq       <= i_message;
            r_exp      <= (i_operation == rme_pkg::OP_DECRYPT) ? i_private_exp : i_public_exp;
            r_mod      <= i_modulus;
            r_mod_zero <= (i_modulus == '0);
            // One reduced by the modulus: zero only for a modulus of one.
            r_acc      <= (i_modulus == WORD_ONE) ? '0 : WORD_ONE;
        end
        if (i_cmd.mul) begin
            r_prod_a <= rme_pkg::t_prod'(r_acc) * rme_pkg::t_prod'(r_sq);
            r_prod_s <= rme_pkg::t_prod'(r_sq) * rme_pkg::t_prod'(r_sq);
            r_rem_a  <= '0;
            r_rem_s  <= '0;
            r_cnt    <= '0;
        end
        if (i_cmd.red_step) begin
            r_prod_a <= r_prod_a << 1;
            r_prod_s <= r_prod_s << 1;
            r_rem_a  <= n_rem_a;
            r_rem_s  <= n_rem_s;
            r_cnt    <= r_cnt + 1'b1;
        end
        if (i_cmd.update) begin
            if (r_exp[0]) begin
                r_acc <= r_mod_zero ? r_prod_a[rme_pkg::DATA_W-1:0] : r_rem_a;
            end
            r_sq  <= r_mod_zero ? r_prod_s[rme_pkg::DATA_W-1:0] : r_rem_s;
            r_exp <= r_exp >> 1;
        end
        if (i_cmd.emit) begin
            r_result <= r_acc;
        end
    end

    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.mod_zero = r_mod_zero;
    assign o_status.red_last = (r_cnt == CNT_LAST);
    assign o_result          = r_result;

    `RME_ASSERT_IMP(a_acc_reduced, i_clk, i_rst_n, i_cmd.mul && !r_mod_zero, r_acc < r_mod)
    `RME_ASSERT_IMP(a_rem_reduced, i_clk, i_rst_n, i_cmd.red_step, (r_rem_a < r_mod) && (r_rem_s < r_mod))

endmodule

// File: hdl/rme_ctrl.sv
`include "assert_macros.svh"

module rme_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rme_pkg::t_dp_cmd    o_cmd,
    input  rme_pkg::t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_RED,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:   o_cmd.load     = i_in_valid;
            S_MUL:    o_cmd.mul      = 1'b1;
            S_RED:    o_cmd.red_step = 1'b1;
            S_UPDATE: o_cmd.update   = 1'b1;
            S_DONE:   o_cmd.emit     = slot_free;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= i_status.exp_zero ? S_DONE : S_MUL;
                end
                S_MUL: begin
                    // With a modulus of zero the low product half is the result.
                    r_state <= i_status.mod_zero ? S_UPDATE : S_RED;
                end
                S_RED: begin
                    if (i_status.red_last) r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_state <= S_CHECK;
                end
                S_DONE: begin
                    if (slot_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `RME_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, (r_state == S_DONE) && slot_free, r_out_valid && (r_state == S_IDLE))
    `RME_ASSERT_NXT(a_red_exit, i_clk, i_rst_n, (r_state == S_RED) && i_status.red_last, r_state == S_UPDATE)

endmodule

// File: hdl/rsa_modexp_cipher_top.sv
// One pass per bit of the bit length of the selected exponent lies between an
// input transaction and its result; with a modulus of zero no pass reduces.
// One item at a time: the next input is taken once the result is in the output
// register.
// Reset (i_rst_n low, synchronous) clears both exponents to 0, the modulus to 1,
// and empties the controller, which clears the output valid.

module rsa_modexp_cipher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] message
    input  logic        i_s_axis_tuser,  // [0] operation: 0 encrypt, 1 decrypt
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // [31:0] result
);

    // The exponentiation scans the exponent from its least significant bit.
    // Each bit takes one pass: both products (accumulator times square and
    // square times square) are formed together by two 32x32 multipliers,
    // then, unless the modulus is zero, reduced together by two restoring
    // dividers at one bit per cycle, and then written back. The multiply into
    // the accumulator is applied only when the exponent bit is set. The
    // reduction sets the pace of the whole block.

    rme_pkg::t_word r_public_exp;
    rme_pkg::t_word r_private_exp;
    rme_pkg::t_word r_modulus;

    rme_pkg::t_dp_cmd    cmd;
    rme_pkg::t_dp_status status;

    // Configuration registers accept a write in every cycle. An index with no
    // register behind it completes the transaction and changes nothing.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_public_exp  <= '0;
            r_private_exp <= '0;
            r_modulus     <= rme_pkg::t_word'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == rme_pkg::CFG_PUBLIC_EXP) begin
                r_public_exp <= i_cfg_data;
            end
            if (i_cfg_index == rme_pkg::CFG_PRIVATE_EXP) begin
                r_private_exp <= i_cfg_data;
            end
            if (i_cfg_index == rme_pkg::CFG_MODULUS) begin
                r_modulus <= i_cfg_data;
            end
        end
    end

    // The controller sequences each exponent bit and owns the output valid.
    rme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // The datapath holds the accumulator, square, exponent shifter,
    // multipliers, reducers and the output data register.
    rme_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_message     (i_s_axis_tdata),
        .i_operation   (i_s_axis_tuser),
        .i_public_exp  (r_public_exp),
        .i_private_exp (r_private_exp),
        .i_modulus     (r_modulus),
        .o_result      (o_m_axis_tdata)
    );

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Pacing of both stream sides. Either side idles at random, about IDLE_PCT percent
    // of the time, except inside a calm window where it never idles.
    localparam int unsigned IDLE_PCT       = 15;
    localparam int unsigned CALM_SENT_LO   = 110;
    localparam int unsigned CALM_SENT_HI   = 160;
    localparam int unsigned CALM_SEEN_LO   = 120;
    localparam int unsigned CALM_SEEN_HI   = 170;

    // After this many results the result side refuses transactions for a long
    // stretch. The block has one item in flight, so it backs up and stalls its input.
    localparam int unsigned HOLDOFF_AT     = 60;
    localparam int unsigned HOLDOFF_CYCLES = 4000;

    // The longest correct gap between transactions is the hold-off above, or one
    // full 32-bit exponent plus idling. The limit is several times the larger of
    // the two.
    localparam int unsigned WATCHDOG_LIMIT = 25000;

    localparam int unsigned RANDOM_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS    = 25;

    // Two composite moduli that come up often: the textbook 61*53 key and the
    // product of the two largest 16-bit primes.
    localparam logic [31:0] TOY_MODULUS    = 32'd3233;
    localparam logic [31:0] BIG_MODULUS    = 32'd4292870399;

    typedef struct packed {
        logic [31:0] message;
        logic        operation;
    } t_cipher_item;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = '0;
    logic [31:0] i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;  // [31:0] message
    logic        i_s_axis_tuser  = 1'b0; // [0] operation: 0 encrypt, 1 decrypt
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;         // [31:0] result

    // Copy of the key registers as the block should hold them. They change only
    // while the block is drained, so the input side can read them freely.
    logic [31:0] public_exp_q  = 32'd0;
    logic [31:0] private_exp_q = 32'd0;
    logic [31:0] modulus_q     = 32'd1;

    t_cipher_item pending_items[$];
    logic [31:0]  expected_ciphertexts[$];

    int unsigned mismatches   = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned quiet_cycles = 0;

    rsa_modexp_cipher_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // One modular product. A modulus of zero stands for 2^32, so the product then
    // simply wraps at 32 bits.
    function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [31:0] m);
        logic [63:0] prod;
        prod = {32'd0, x[31:0]} * {32'd0, y[31:0]};
        if (m == 32'd0) return {32'd0, prod[31:0]};
        return prod % {32'd0, m};
    endfunction

    // Right-to-left square-and-multiply. The base is not reduced up front; the
    // first multiply or square takes care of that, and the final reduction covers
    // a zero exponent (1 mod 1 is 0).
    function automatic logic [31:0] mod_power(logic [31:0] base, logic [31:0] expo,
                                              logic [31:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1;
        sq  = {32'd0, base};
        while (expo != 32'd0) begin
            if (expo[0]) acc = mulmod(acc, sq, m);
            sq   = mulmod(sq, sq, m);
            expo = expo >> 1;
        end
        if (m == 32'd0) return acc[31:0];
        return 32'(acc % {32'd0, m});
    endfunction

    // Exponents of every bit length, so that the run time per item varies and most
    // items stay well below the full 32-bit latency.
    function automatic logic [31:0] random_exponent();
        int unsigned pick;
        int unsigned len;
        logic [31:0] mask;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'd0;
        if (pick == 1) return 32'hFFFF_FFFF;
        len  = $urandom_range(1, 32);
        mask = (len == 32) ? 32'hFFFF_FFFF : ((32'd1 << len) - 32'd1);
        return ($urandom & mask) | (32'd1 << (len - 1));
    endfunction

    // Large moduli with the top bit set, plus small ones, mid-sized ones and
    // the corners: one, all ones, and zero (which the block treats as 2^32).
    function automatic logic [31:0] random_modulus();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 32'd1;
        if (pick == 1) return 32'hFFFF_FFFF;
        if (pick == 2) return 32'd0;
        if (pick <= 6) return 32'($urandom_range(2, 1000));
        if (pick == 7) return BIG_MODULUS;
        if (pick <= 13) return $urandom | 32'h8000_0000;
        return ($urandom >> $urandom_range(1, 30)) | 32'd2;
    endfunction

    // Messages are frequently at or above the modulus on purpose, since the block
    // must reduce them on the way.
    function automatic logic [31:0] random_message();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'd0;
        if (pick == 1) return 32'hFFFF_FFFF;
        if (pick == 2) return modulus_q - 32'd1;
        if (pick == 3) return modulus_q;
        return $urandom;
    endfunction

    task automatic queue_item(logic [31:0] message, logic operation);
        t_cipher_item it;
        it.message   = message;
        it.operation = operation;
        pending_items.push_back(it);
    endtask

    // Waits at falling edges, where every queue and signal has settled, until no
    // item is waiting, offered or in flight. Every item gives a result, so once the
    // last result has arrived the block is idle again; a short pause covers its
    // return to the idle state.
    task automatic wait_until_drained();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_s_axis_tvalid ||
               expected_ciphertexts.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One transaction on the configuration channel. The shadow copy is updated at
    // the edge where the write takes place.
    task automatic write_register(rme_pkg::t_cfg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            rme_pkg::CFG_PUBLIC_EXP:  public_exp_q  = value;
            rme_pkg::CFG_PRIVATE_EXP: private_exp_q = value;
            rme_pkg::CFG_MODULUS:     modulus_q     = value;
            default: ;
        endcase
    endtask

    // Drains the block, then loads a complete key set.
    task automatic load_key(logic [31:0] pub_exp, logic [31:0] priv_exp, logic [31:0] m);
        wait_until_drained();
        write_register(rme_pkg::CFG_PUBLIC_EXP, pub_exp);
        write_register(rme_pkg::CFG_PRIVATE_EXP, priv_exp);
        write_register(rme_pkg::CFG_MODULUS, m);
        @(negedge i_clk);
    endtask

    // Input side. When the offered item was taken (or nothing is offered), the next
    // pending item is presented unless this cycle is picked for idling. The expected
    // result is computed at the edge where the input transaction happens.
    always @(posedge i_clk) begin : drive_messages
        t_cipher_item nxt;
        logic         calm;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_ciphertexts.push_back(mod_power(i_s_axis_tdata,
                    (i_s_axis_tuser == rme_pkg::OP_DECRYPT) ? private_exp_q : public_exp_q,
                    modulus_q));
                items_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                calm = (items_sent >= CALM_SENT_LO) && (items_sent < CALM_SENT_HI);
                if (pending_items.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = pending_items.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= nxt.message;
                    i_s_axis_tuser  <= nxt.operation;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side. Each result transaction is checked against the oldest
    // expectation. Ready is dropped at random, held low for one long stretch once
    // HOLDOFF_AT results have arrived, and held high throughout a calm window.
    always @(posedge i_clk) begin : check_results
        int unsigned holdoff_left;
        logic        holdoff_done;
        logic [31:0] want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            holdoff_left = 0;
            holdoff_done = 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_ciphertexts.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $realtime, o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_ciphertexts.pop_front();
                    if (o_m_axis_tdata !== want) begin
                        $display("%0t: result mismatch: expected %h, actual %h",
                                 $realtime, want, o_m_axis_tdata);
                        mismatches++;
                    end
                end
                results_seen++;
            end
            if (!holdoff_done && results_seen == HOLDOFF_AT) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                i_m_axis_tready <= 1'b0;
            end else if (results_seen >= CALM_SEEN_LO && results_seen < CALM_SEEN_HI) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: any transaction on any channel restarts the count. A hang anywhere,
    // including a result that never shows up at the end, ends the run here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) ||
            (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Keys straight out of reset: both exponents zero and a modulus of one, so
        // everything comes back as zero.
        queue_item(32'hFFFF_FFFF, rme_pkg::OP_ENCRYPT);
        queue_item(32'h0000_0001, rme_pkg::OP_DECRYPT);

        // Zero exponents with a real modulus give one, whatever the message.
        load_key(32'd0, 32'd0, 32'hFFFF_FFFF);
        queue_item(32'd0, rme_pkg::OP_ENCRYPT);
        queue_item(32'hFFFF_FFFF, rme_pkg::OP_DECRYPT);

        // Largest modulus, a tiny public exponent and an all-ones private one, the
        // slowest case. Messages at the field corners, one equal to the modulus.
        load_key(32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(32'd0, rme_pkg::OP_DECRYPT);
        queue_item(32'd1, rme_pkg::OP_ENCRYPT);
        queue_item(32'hFFFF_FFFF, rme_pkg::OP_DECRYPT);
        queue_item(32'h8000_0000, rme_pkg::OP_ENCRYPT);

        // A textbook key pair: 65 encrypts to 2790 and 2790 decrypts back to 65.
        load_key(32'd17, 32'd2753, TOY_MODULUS);
        queue_item(32'd65, rme_pkg::OP_ENCRYPT);
        queue_item(32'd2790, rme_pkg::OP_DECRYPT);
        queue_item(32'hFFFF_FFFF, rme_pkg::OP_ENCRYPT);

        // A modulus of one wipes out any exponent.
        load_key(32'hFFFF_FFFF, 32'd1, 32'd1);
        queue_item(32'hDEAD_BEEF, rme_pkg::OP_ENCRYPT);
        queue_item(32'hFFFF_FFFF, rme_pkg::OP_DECRYPT);

        // A modulus of zero stands for 2^32: plain wrapping arithmetic.
        load_key(32'hFFFF_FFFF, 32'd5, 32'd0);
        queue_item(32'd3, rme_pkg::OP_ENCRYPT);
        queue_item(32'hFFFF_FFFF, rme_pkg::OP_DECRYPT);
        queue_item(32'h1234_5678, rme_pkg::OP_ENCRYPT);

        // Random keys, each held for a batch of random messages.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_key(random_exponent(), random_exponent(), random_modulus());
            for (int k = 0; k < PHASE_ITEMS; k++)
                queue_item(random_message(),
                           ($urandom_range(0, 1) != 0) ? rme_pkg::OP_DECRYPT
                                                       : rme_pkg::OP_ENCRYPT);
        end

        // Everything must come back, and nothing more may follow.
        wait_until_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: rsa_modexp_cipher_top.f
+incdir+hdl
hdl/rme_pkg.sv
hdl/rme_datapath.sv
hdl/rme_ctrl.sv
hdl/rsa_modexp_cipher_top.sv
tb/tb_top.sv
